// ===== sv/lnr_pkg.sv =====
// Shared types, widths and codes for the clipped line rasterizer.
// No dependencies; imported by every module of the block.
package lnr_pkg;

   localparam int COORD_BITS = 12;
   localparam int ERR_BITS   = COORD_BITS + 1;
   localparam int CLIP_BITS  = 11;
   localparam int COLOR_BITS = 8;
   localparam int CMP_BITS   = (COORD_BITS > CLIP_BITS) ? COORD_BITS : CLIP_BITS;

   localparam int REQ_FIELD_BITS = 4 * COORD_BITS + COLOR_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 2 * COORD_BITS + COLOR_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic CMD_START   = 1'b0;
   localparam logic CMD_ADVANCE = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] REG_CLIP_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_CLIP_HEIGHT = 2'd1;

   localparam logic [CLIP_BITS-1:0] CLIP_WIDTH_RESET  = 11'd1024;
   localparam logic [CLIP_BITS-1:0] CLIP_HEIGHT_RESET = 11'd768;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [COLOR_BITS-1:0] color_type;
   typedef logic [CLIP_BITS-1:0]  clip_type;

   typedef struct packed {
      logic      command;
      coord_type x_start;
      coord_type y_start;
      coord_type x_end;
      coord_type y_end;
      color_type line_color;
   } req_item_type;

   typedef struct packed {
      coord_type                cur_x;
      coord_type                cur_y;
      coord_type                major_end;
      coord_type                long_span;
      coord_type                short_span;
      logic [ERR_BITS-1:0]      error_acc;
      logic                     major_dir_neg;
      logic                     minor_dir_neg;
      logic                     x_is_major;
      logic                     active;
      color_type                held_color;
   } line_state_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      color_type color;
      logic      visible;
      logic      last;
   } pixel_type;

endpackage

// ===== sv/lnr_setup.sv =====
// Start-command decode: spans, directions and major axis from two endpoints.
// Depends on lnr_pkg.
module lnr_setup (
   input  lnr_pkg::req_item_type   item,
   output lnr_pkg::line_state_type line_state
);
   import lnr_pkg::*;

   logic signed [ERR_BITS-1:0] dx;
   logic signed [ERR_BITS-1:0] dy;
   logic [ERR_BITS-1:0]        dx_abs;
   logic [ERR_BITS-1:0]        dy_abs;
   coord_type                  ax;
   coord_type                  ay;
   logic                       xneg;
   logic                       yneg;
   logic                       x_major;

   always_comb begin
      // sign-extend by one bit so the difference cannot overflow
      dx = $signed({item.x_end[COORD_BITS-1], item.x_end})
         - $signed({item.x_start[COORD_BITS-1], item.x_start});
      dy = $signed({item.y_end[COORD_BITS-1], item.y_end})
         - $signed({item.y_start[COORD_BITS-1], item.y_start});
      xneg = dx[ERR_BITS-1];
      yneg = dy[ERR_BITS-1];
      dx_abs = xneg ? ERR_BITS'(-dx) : ERR_BITS'(dx);
      dy_abs = yneg ? ERR_BITS'(-dy) : ERR_BITS'(dy);
      ax = dx_abs[COORD_BITS-1:0];
      ay = dy_abs[COORD_BITS-1:0];
      // equal spans step along y
      x_major = ay < ax;

      line_state.cur_x      = item.x_start;
      line_state.cur_y      = item.y_start;
      line_state.held_color = item.line_color;
      line_state.x_is_major = x_major;
      line_state.active     = 1'b1;
      if (x_major) begin
         line_state.major_end     = item.x_end;
         line_state.long_span     = ax;
         line_state.short_span    = ay;
         line_state.major_dir_neg = xneg;
         line_state.minor_dir_neg = yneg;
      end else begin
         line_state.major_end     = item.y_end;
         line_state.long_span     = ay;
         line_state.short_span    = ax;
         line_state.major_dir_neg = yneg;
         line_state.minor_dir_neg = xneg;
      end
      line_state.error_acc = ERR_BITS'(line_state.long_span >> 1);
   end

endmodule

// ===== sv/lnr_step.sv =====
// Advance step: current pixel with clip flag, and the line state after it.
// Depends on lnr_pkg.
module lnr_step (
   input  lnr_pkg::line_state_type line_state,
   input  lnr_pkg::clip_type       clip_width,
   input  lnr_pkg::clip_type       clip_height,
   output lnr_pkg::pixel_type      pixel,
   output lnr_pkg::line_state_type line_state_next
);
   import lnr_pkg::*;

   coord_type           major;
   logic                is_last;
   logic [ERR_BITS-1:0] err_sum;
   logic                minor_step;
   logic                x_in;
   logic                y_in;

   always_comb begin
      major   = line_state.x_is_major ? line_state.cur_x : line_state.cur_y;
      is_last = major == line_state.major_end;

      x_in = !line_state.cur_x[COORD_BITS-1]
           && (CMP_BITS'(line_state.cur_x) < CMP_BITS'(clip_width));
      y_in = !line_state.cur_y[COORD_BITS-1]
           && (CMP_BITS'(line_state.cur_y) < CMP_BITS'(clip_height));

      pixel.x       = line_state.cur_x;
      pixel.y       = line_state.cur_y;
      pixel.color   = line_state.held_color;
      pixel.visible = x_in && y_in;
      pixel.last    = is_last;

      err_sum    = line_state.error_acc + ERR_BITS'(line_state.short_span);
      minor_step = err_sum > ERR_BITS'(line_state.long_span);

      line_state_next = line_state;
      if (line_state.active) begin
         if (is_last) begin
            line_state_next.active = 1'b0;
         end else begin
            line_state_next.error_acc = minor_step
               ? err_sum - ERR_BITS'(line_state.long_span) : err_sum;
            if (line_state.x_is_major) begin
               line_state_next.cur_x = line_state.major_dir_neg
                  ? line_state.cur_x - 1'b1 : line_state.cur_x + 1'b1;
               if (minor_step) begin
                  line_state_next.cur_y = line_state.minor_dir_neg
                     ? line_state.cur_y - 1'b1 : line_state.cur_y + 1'b1;
               end
            end else begin
               line_state_next.cur_y = line_state.major_dir_neg
                  ? line_state.cur_y - 1'b1 : line_state.cur_y + 1'b1;
               if (minor_step) begin
                  line_state_next.cur_x = line_state.minor_dir_neg
                     ? line_state.cur_x - 1'b1 : line_state.cur_x + 1'b1;
               end
            end
         end
      end
   end

endmodule

// ===== sv/line_rasterizer_clipped.sv =====
// Top level of the clipped line rasterizer: input register, line state,
// clip registers and result register. Depends on lnr_pkg, lnr_setup, lnr_step.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_tvalid/req_tready | tdata endpoints+color, tuser command
//   rsp     | out       | rsp_tvalid/rsp_tready | tdata pixel+color, tuser visible, tlast
//   csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// One command per clock sustained while rsp_tready holds; the pixel of an advance passes
// through the input register, then the result register, on its way to rsp, and a stalled
// rsp can hold it in the input register. The rate is set by the error accumulator and
// coordinate update, which are combinational.
// Reset leaves the block idle with clip window 1024 x 768.
// A stalled result holds in the result register while one more command waits in
// the input register; req_tready drops only when both are full.
module line_rasterizer_clipped (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // x_start, y_start, x_end, y_end, line_color
   input  logic [lnr_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   // command
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // pixel_x, pixel_y, pixel_color
   output logic [lnr_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   // visible
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lnr_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [lnr_pkg::CLIP_BITS-1:0]        csr_data
);
   import lnr_pkg::*;

   localparam int XS_LSB  = 0;
   localparam int YS_LSB  = COORD_BITS;
   localparam int XE_LSB  = 2 * COORD_BITS;
   localparam int YE_LSB  = 3 * COORD_BITS;
   localparam int COL_LSB = 4 * COORD_BITS;

   logic           in_valid_ff;
   req_item_type   in_item_ff;
   req_item_type   req_item;
   line_state_type state_ff;
   line_state_type state_in;
   line_state_type start_state;
   line_state_type step_state;
   pixel_type      step_pixel;
   logic           out_valid_ff;
   logic           out_valid_in;
   pixel_type      out_pixel_ff;
   clip_type       clip_width_ff;
   clip_type       clip_height_ff;
   logic           fire;
   logic           out_load;

   assign req_item.command    = req_tuser;
   assign req_item.x_start    = req_tdata[XS_LSB +: COORD_BITS];
   assign req_item.y_start    = req_tdata[YS_LSB +: COORD_BITS];
   assign req_item.x_end      = req_tdata[XE_LSB +: COORD_BITS];
   assign req_item.y_end      = req_tdata[YE_LSB +: COORD_BITS];
   assign req_item.line_color = req_tdata[COL_LSB +: COLOR_BITS];

   // process the held command when the result register can take its pixel
   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign out_load   = fire && (in_item_ff.command == CMD_ADVANCE) && state_ff.active;
   assign csr_ready  = 1'b1;

   lnr_setup u_setup (
      .item       (in_item_ff),
      .line_state (start_state)
   );

   lnr_step u_step (
      .line_state      (state_ff),
      .clip_width      (clip_width_ff),
      .clip_height     (clip_height_ff),
      .pixel           (step_pixel),
      .line_state_next (step_state)
   );

   always_comb begin
      state_in = state_ff;
      if (fire) begin
         case (in_item_ff.command)
            CMD_START:   state_in = start_state;
            CMD_ADVANCE: state_in = step_state;
            default:     state_in = state_ff;
         endcase
      end
      out_valid_in = out_load || (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= req_item;
      end
      if (out_load) begin
         out_pixel_ff <= step_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_width_ff  <= CLIP_WIDTH_RESET;
         clip_height_ff <= CLIP_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_CLIP_WIDTH:  clip_width_ff  <= csr_data;
            REG_CLIP_HEIGHT: clip_height_ff <= csr_data;
            default:         ;
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({out_pixel_ff.color, out_pixel_ff.y, out_pixel_ff.x});
   assign rsp_tuser  = out_pixel_ff.visible;
   assign rsp_tlast  = out_pixel_ff.last;

   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("input stalled without both registers full");

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (out_load && step_pixel.last) |=> !state_ff.active)
      else $error("line still active after its final pixel");

   a_start_arms_line: assert property (@(posedge clock) disable iff (reset)
      (fire && in_item_ff.command == CMD_START) |=> (state_ff.active && !$past(out_load)))
      else $error("start transaction did not arm the line or produced a pixel");

   a_span_order: assert property (@(posedge clock) disable iff (reset)
      state_ff.active |-> (state_ff.long_span >= state_ff.short_span))
      else $error("minor span exceeds major span");

   a_error_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.active |-> (state_ff.error_acc <= ERR_BITS'(state_ff.long_span)))
      else $error("error accumulator beyond long span");

endmodule

// ===== sim/tb_line_rasterizer_clipped.sv =====
// Self-checking testbench for line_rasterizer_clipped: predicts every pixel and
// compares it field by field. Depends on lnr_pkg and the rasterizer RTL only.
`timescale 1ns / 100ps

module tb_line_rasterizer_clipped;
   import lnr_pkg::*;

   localparam int COORD_MIN        = -(1 << (COORD_BITS - 1));
   localparam int COORD_MAX        = (1 << (COORD_BITS - 1)) - 1;
   localparam int PHASES           = 6;
   localparam int ITEMS_PER_PHASE  = 125;
   localparam int SETTLE_CYCLES    = 8;
   localparam int WATCHDOG_LIMIT   = 2000;

   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_HI = 2'd3;

   localparam int STALL_NONE     = 0;
   localparam int STALL_COIN     = 1;
   localparam int STALL_RARE     = 2;
   localparam int STALL_PERIODIC = 3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata  = '0;
   logic                      req_tuser  = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic                      rsp_tuser;
   logic                      rsp_tlast;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   clip_type                  csr_data   = '0;

   line_rasterizer_clipped DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Predicted line state and clip window
   coord_type           pos_x, pos_y, major_stop, span_long, span_short;
   logic [ERR_BITS-1:0] err_acc;
   logic                major_neg, minor_neg, x_major, line_active;
   color_type           color_held;
   clip_type            clip_w = CLIP_WIDTH_RESET;
   clip_type            clip_h = CLIP_HEIGHT_RESET;

   req_item_type pending_commands[$];
   pixel_type    expected_pixels[$];
   int           pushed_count   = 0;
   int           accepted_count = 0;
   int           error_count    = 0;
   int           idle_cycles    = 0;

   task automatic rasterize_command(input req_item_type it);
      int        xs, ys, xe, ye, dx, dy, ax, ay;
      pixel_type px;
      coord_type major;
      if (it.command == CMD_START) begin
         xs = int'($signed(it.x_start));
         ys = int'($signed(it.y_start));
         xe = int'($signed(it.x_end));
         ye = int'($signed(it.y_end));
         dx = xe - xs;
         dy = ye - ys;
         ax = (dx < 0) ? -dx : dx;
         ay = (dy < 0) ? -dy : dy;
         pos_x      = it.x_start;
         pos_y      = it.y_start;
         color_held = it.line_color;
         // equal spans step along y
         x_major = ay < ax;
         if (x_major) begin
            major_stop = it.x_end;
            span_long  = coord_type'(ax);
            span_short = coord_type'(ay);
            major_neg  = dx < 0;
            minor_neg  = dy < 0;
         end else begin
            major_stop = it.y_end;
            span_long  = coord_type'(ay);
            span_short = coord_type'(ax);
            major_neg  = dy < 0;
            minor_neg  = dx < 0;
         end
         err_acc     = {1'b0, span_long} >> 1;
         line_active = 1'b1;
      end else if (line_active) begin
         major      = x_major ? pos_x : pos_y;
         px.x       = pos_x;
         px.y       = pos_y;
         px.color   = color_held;
         px.visible = !pos_x[COORD_BITS-1] && (pos_x < clip_w) &&
                      !pos_y[COORD_BITS-1] && (pos_y < clip_h);
         px.last    = (major == major_stop);
         expected_pixels.push_back(px);
         if (px.last) begin
            line_active = 1'b0;
         end else begin
            err_acc = err_acc + span_short;
            if (err_acc > span_long) begin
               err_acc = err_acc - span_long;
               if (x_major) pos_y = minor_neg ? pos_y - 1'b1 : pos_y + 1'b1;
               else         pos_x = minor_neg ? pos_x - 1'b1 : pos_x + 1'b1;
            end
            if (x_major) pos_x = major_neg ? pos_x - 1'b1 : pos_x + 1'b1;
            else         pos_y = major_neg ? pos_y - 1'b1 : pos_y + 1'b1;
         end
      end
   endtask

   function automatic int clamp_coord(int v);
      if (v < COORD_MIN) return COORD_MIN;
      if (v > COORD_MAX) return COORD_MAX;
      return v;
   endfunction

   function automatic int rand_full();
      return int'($urandom_range(0, COORD_MAX - COORD_MIN)) + COORD_MIN;
   endfunction

   // Half of the picks around the clip edges so visibility toggles
   function automatic int pick_coord(int lim);
      case ($urandom_range(0, 3))
         0:       return rand_full();
         1:       return int'($urandom_range(0, 12)) - 6;
         2:       return clamp_coord(lim + int'($urandom_range(0, 12)) - 6);
         default: return (lim > 0) ? int'($urandom_range(0, lim - 1)) : 0;
      endcase
   endfunction

   function automatic int pick_end(int c);
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return clamp_coord(c + int'($urandom_range(0, 24)) - 12);
      if (r < 97) return clamp_coord(c + int'($urandom_range(0, 300)) - 150);
      return rand_full();
   endfunction

   function automatic void push_command(logic cmd, int xs, int ys, int xe, int ye, int color);
      req_item_type it;
      it.command    = cmd;
      it.x_start    = coord_type'(xs);
      it.y_start    = coord_type'(ys);
      it.x_end      = coord_type'(xe);
      it.y_end      = coord_type'(ye);
      it.line_color = color_type'(color);
      pending_commands.push_back(it);
      pushed_count++;
   endfunction

   // Start plus a number of advances carrying junk payload
   function automatic int queue_line(int xs, int ys, int xe, int ye, int color, int adv);
      push_command(CMD_START, xs, ys, xe, ye, color);
      for (int i = 0; i < adv; i++)
         push_command(CMD_ADVANCE, rand_full(), rand_full(), rand_full(), rand_full(),
                      $urandom_range(0, 255));
      return adv + 1;
   endfunction

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx, input clip_type val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_CLIP_WIDTH)  clip_w = val;
      if (idx == REG_CLIP_HEIGHT) clip_h = val;
   endtask

   // Driver: bursts of commands separated by random gaps
   req_item_type driven_item;
   int           burst_left = 0;
   int           gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            rasterize_command(driven_item);
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_commands.size() > 0) begin
               driven_item = pending_commands.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= driven_item.command;
               req_tdata  <= {driven_item.line_color, driven_item.y_end, driven_item.x_end,
                              driven_item.y_start, driven_item.x_start};
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string what, input int exp_v, input int got_v);
      if (exp_v != got_v) begin
         $display("%0t: pixel %s mismatch, expected %0d, actual %0d", $realtime, what,
                  exp_v, got_v);
         error_count++;
      end
   endtask

   // Monitor: checks each pixel transaction and drives the stall pattern
   int        stall_mode  = STALL_NONE;
   int        stall_left  = 0;
   int        stall_tick  = 0;
   pixel_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: unexpected pixel x %0d y %0d", $realtime,
                        $signed(rsp_tdata[COORD_BITS-1:0]),
                        $signed(rsp_tdata[2*COORD_BITS-1:COORD_BITS]));
               error_count++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("x", int'($signed(want.x)),
                           int'($signed(rsp_tdata[COORD_BITS-1:0])));
               check_field("y", int'($signed(want.y)),
                           int'($signed(rsp_tdata[2*COORD_BITS-1:COORD_BITS])));
               check_field("color", int'(want.color),
                           int'(rsp_tdata[2*COORD_BITS+COLOR_BITS-1:2*COORD_BITS]));
               check_field("visible", int'(want.visible), int'(rsp_tuser));
               check_field("last", int'(want.last), int'(rsp_tlast));
            end
         end
         if (stall_left == 0) begin
            stall_mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
            stall_left = $urandom_range(20, 200);
         end else begin
            stall_left--;
         end
         stall_tick++;
         case (stall_mode)
            STALL_NONE: rsp_tready <= 1'b1;
            STALL_COIN: rsp_tready <= ($urandom_range(0, 1) != 0);
            STALL_RARE: rsp_tready <= ($urandom_range(0, 7) != 0);
            default:    rsp_tready <= ((stall_tick % 5) != 4);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int count, r, xs, ys, xe, ye, span, adv;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            1: begin
               csr_write(REG_CLIP_WIDTH, 11'd2047);
               csr_write(REG_CLIP_HEIGHT, 11'd2047);
            end
            2: begin
               csr_write(REG_CLIP_WIDTH, 11'd1);
               csr_write(REG_CLIP_HEIGHT, 11'd1);
            end
            3: begin
               // zero window: nothing visible
               csr_write(REG_CLIP_WIDTH, 11'd0);
               csr_write(REG_CLIP_HEIGHT, 11'd0);
            end
            4: begin
               csr_write(REG_CLIP_WIDTH, clip_type'($urandom_range(1, 2047)));
               csr_write(REG_CLIP_HEIGHT, clip_type'($urandom_range(1, 2047)));
               csr_write(REG_SPARE_LO, clip_type'($urandom_range(0, 2047)));
               csr_write(REG_SPARE_HI, clip_type'($urandom_range(0, 2047)));
            end
            5: begin
               csr_write(REG_CLIP_WIDTH, 11'd640);
               csr_write(REG_CLIP_HEIGHT, 11'd480);
            end
            default: ;
         endcase
         @(negedge clock);

         count = 0;
         if (phase == 0) begin
            // advance while idle
            push_command(CMD_ADVANCE, rand_full(), rand_full(), rand_full(), rand_full(), 0);
            // zero-length line, then an advance after it ends
            count += queue_line(0, 0, 0, 0, 255, 2);
            count += queue_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0, 3);
            // restart while the previous line is still running
            count += queue_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, 170, 2);
            count += queue_line(1022, 5, 1025, 5, 85, 4);
            count += queue_line(-1, 767, 2, 765, 1, 4);
            count += queue_line(2, -1, 0, 2, 254, 4);
         end

         while (count < ITEMS_PER_PHASE) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
               push_command(logic'($urandom_range(0, 1)), rand_full(), rand_full(),
                            rand_full(), rand_full(), $urandom_range(0, 255));
               count++;
            end else begin
               xs = pick_coord(int'(clip_w));
               ys = pick_coord(int'(clip_h));
               xe = pick_end(xs);
               ye = pick_end(ys);
               span = (xe > xs) ? xe - xs : xs - xe;
               if (((ye > ys) ? ye - ys : ys - ye) > span)
                  span = (ye > ys) ? ye - ys : ys - ye;
               span++;
               r = $urandom_range(0, 99);
               if (span > 400)  adv = $urandom_range(0, 30);
               else if (r < 80) adv = span;
               else if (r < 90) adv = span + $urandom_range(1, 3);
               else             adv = $urandom_range(0, span - 1);
               count += queue_line(xs, ys, xe, ye, $urandom_range(0, 255), adv);
            end
         end

         // hold off until every command is taken and every pixel is back
         while (accepted_count != pushed_count || expected_pixels.size() != 0)
            @(negedge clock);
         repeat (SETTLE_CYCLES) @(negedge clock);
      end

      if (error_count == 0 && expected_pixels.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
sv/lnr_pkg.sv
sv/lnr_setup.sv
sv/lnr_step.sv
sv/line_rasterizer_clipped.sv
sim/tb_line_rasterizer_clipped.sv
